// ----- sv/isoa_pkg.sv -----
// isoa_pkg: types, register codes and constants for the input source ownership arbiter
// no dependencies; imported by every module of the block

package isoa_pkg;

  // item kinds
  localparam logic KIND_KEY_WORD = 1'b0;
  localparam logic KIND_TICK     = 1'b1;

  // register indexes on the configuration port
  localparam logic [1:0] REG_STICK_THR  = 2'd0;
  localparam logic [1:0] REG_TRIG_THR   = 2'd1;
  localparam logic [1:0] REG_BACKGROUND = 2'd2;
  localparam logic [1:0] REG_AUTO_SW    = 2'd3;

  // register reset values
  localparam logic [14:0] STICK_THR_RST = 15'd8192;
  localparam logic [14:0] TRIG_THR_RST  = 15'd8192;

  // threshold clamp range, 0.05 .. 0.95 in Q0.15
  localparam logic [14:0] THR_MIN = 15'd1638;
  localparam logic [14:0] THR_MAX = 15'd31129;

  // axis motion step, 0.10 in Q0.15
  localparam logic [17:0] MOVE_STEP = 18'd3277;

  // key code ranges that count as keyboard activity
  localparam int unsigned KEY_FIRST      = 1;
  localparam int unsigned KEY_LAST       = 254;
  localparam int unsigned KEY_SKIP_FIRST = 'hC3;
  localparam int unsigned KEY_SKIP_LAST  = 'hDA;

  typedef struct packed {
    logic               kind;
    logic [1:0]         word_index;
    logic [63:0]        key_word;
    logic               connected;
    logic               focused;
    logic [63:0]        stick_axes;
    logic [31:0]        trigger_axes;
    logic [15:0]        pad_buttons;
    logic signed [15:0] mouse_dx;
    logic signed [15:0] mouse_dy;
    logic [1:0]         wheel;
  } in_item_t;

  typedef struct packed {
    logic use_controller;
    logic owner_is_keyboard;
  } out_item_t;

  typedef struct packed {
    logic [14:0] stick_thr;
    logic [14:0] trig_thr;
    logic        background_input;
    logic        auto_switch;
  } cfg_t;

  // what the lanes found on one tick
  typedef struct packed {
    logic axis_act;
    logic key_act;
  } lane_act_t;

  function automatic logic [14:0] clamp_thr(input logic [14:0] t);
    logic [14:0] r;
    r = t;
    if (t < THR_MIN) begin
      r = THR_MIN;
    end else if (t > THR_MAX) begin
      r = THR_MAX;
    end
    return r;
  endfunction

  // keys of one 64-key group that may signal keyboard activity
  function automatic logic [63:0] key_mask(input int unsigned w);
    logic [63:0] m;
    int unsigned key;
    m = '0;
    for (int unsigned i = 0; i < 64; i++) begin
      key = 64 * w + i;
      if (key >= KEY_FIRST && key <= KEY_LAST &&
          !(key >= KEY_SKIP_FIRST && key <= KEY_SKIP_LAST)) begin
        m[i] = 1'b1;
      end
    end
    return m;
  endfunction

endpackage

// ----- sv/isoa_axis_lane.sv -----
// isoa_axis_lane: one gamepad axis with its anchor, flags a wake move
// depends on isoa_pkg (MOVE_STEP)

module isoa_axis_lane (
  input  logic               clk,
  input  logic               rst,
  input  logic               tick,
  input  logic               connected,
  input  logic signed [16:0] value,
  input  logic [14:0]        thr,
  output logic               act
);
  import isoa_pkg::*;

  logic signed [16:0] anchor;
  logic signed [16:0] anchor_next;
  logic [16:0]        mag_v;
  logic [16:0]        mag_a;
  logic signed [17:0] diff;
  logic [17:0]        mag_d;
  logic               below_v;
  logic               below_a;
  logic               far;

  // magnitudes of value, anchor and their distance
  always_comb begin
    mag_v   = value[16] ? 17'(-value) : 17'(value);
    mag_a   = anchor[16] ? 17'(-anchor) : 17'(anchor);
    diff    = {value[16], value} - {anchor[16], anchor};
    mag_d   = diff[17] ? 18'(-diff) : 18'(diff);
    below_v = mag_v < {2'b00, thr};
    below_a = mag_a < {2'b00, thr};
    far     = mag_d >= MOVE_STEP;
  end

  assign act = connected && !below_v && (below_a || far);

  // anchor clears while disconnected, else follows the value unless value and anchor are both past threshold and near
  always_comb begin
    anchor_next = anchor;
    if (!connected) begin
      anchor_next = '0;
    end else if (below_v || below_a || far) begin
      anchor_next = value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      anchor <= '0;
    end else if (tick) begin
      anchor <= anchor_next;
    end
  end

endmodule

// ----- sv/isoa_key_lane.sv -----
// isoa_key_lane: one 64-key group, rising edges against the key history
// depends on isoa_pkg (no types used beyond plain vectors)

module isoa_key_lane (
  input  logic        clk,
  input  logic        rst,
  input  logic        tick_focused,
  input  logic [63:0] keys,
  input  logic [63:0] mask,
  output logic        act
);
  import isoa_pkg::*;

  logic [63:0] history;
  logic [63:0] now_keys;

  assign now_keys = keys & mask;
  assign act      = |(now_keys & ~history);

  // history moves only on focused ticks
  always_ff @(posedge clk) begin
    if (rst) begin
      history <= '0;
    end else if (tick_focused) begin
      history <= now_keys;
    end
  end

endmodule

// ----- sv/isoa_owner.sv -----
// isoa_owner: merges lane findings, button edges and mouse motion into ownership
// depends on isoa_pkg (in_item_t, out_item_t, cfg_t, lane_act_t)

module isoa_owner (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 tick,
  input  isoa_pkg::in_item_t   item,
  input  isoa_pkg::lane_act_t  lanes,
  input  isoa_pkg::cfg_t       cfg,
  output isoa_pkg::out_item_t  result
);
  import isoa_pkg::*;

  logic        owner;
  logic        owner_next;
  logic [15:0] btn_hist;
  logic        btn_edge;
  logic        pad_act;
  logic        mouse_act;
  logic        kbm_act;
  logic        use_ctrl;

  // gamepad and keyboard/mouse activity
  always_comb begin
    btn_edge  = |(item.pad_buttons & ~btn_hist);
    pad_act   = item.connected && (lanes.axis_act || btn_edge);
    mouse_act = (item.mouse_dx != '0) || (item.mouse_dy != '0) || (item.wheel != '0);
    kbm_act   = item.focused && (lanes.key_act || mouse_act);
  end

  // ownership decision
  always_comb begin
    owner_next = owner;
    use_ctrl   = 1'b0;
    priority if (!item.focused && !cfg.background_input) begin
      owner_next = 1'b1;
      use_ctrl   = 1'b0;
    end else if (!cfg.auto_switch) begin
      owner_next = 1'b0;
      use_ctrl   = item.connected;
    end else begin
      if (!item.connected || kbm_act) begin
        owner_next = 1'b1;
      end else if (pad_act) begin
        owner_next = 1'b0;
      end
      use_ctrl = !owner_next;
    end
  end

  always_comb begin
    result.use_controller    = use_ctrl;
    result.owner_is_keyboard = owner_next;
  end

  // owner and button history update on every tick
  always_ff @(posedge clk) begin
    if (rst) begin
      owner    <= 1'b0;
      btn_hist <= '0;
    end else if (tick) begin
      owner    <= owner_next;
      btn_hist <= item.connected ? item.pad_buttons : 16'h0000;
    end
  end

endmodule

// ----- sv/input_source_ownership_arbiter.sv -----
// input_source_ownership_arbiter: top level, configuration, key staging, lanes, output skid
// depends on isoa_pkg, isoa_axis_lane, isoa_key_lane, isoa_owner
//
//   channel   handshake              payload    direction
//   in        in_valid / in_ready    in_item    key word or tick item in
//   out       out_valid / out_ready  out_item   one result per tick item out
//   cfg       cfg_write              cfg_index, cfg_data   register write in
//
// One item is taken per cycle; a tick's result is registered in the output register,
// or in the skid entry while that register holds an unpopped result. Six axis lanes
// and KEY_WORDS key lanes evaluate a tick in the accept cycle, and the owner stage
// merges them. The output register plus a one-entry skid stage hold two results;
// in_ready drops only while the skid entry is full. Reset clears ownership, anchors
// and histories at once; staged key words hold no value until written.

module input_source_ownership_arbiter #(
  parameter int KEY_WORDS = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  isoa_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output isoa_pkg::out_item_t out_item,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [14:0]         cfg_data
);
  import isoa_pkg::*;

  cfg_t        cfg;
  logic        accept;
  logic        tick;
  logic        stage_key;
  logic [63:0] staged_keys [KEY_WORDS];
  logic [5:0]  axis_act;
  logic [KEY_WORDS-1:0] key_act;
  logic [14:0] stick_thr_c;
  logic [14:0] trig_thr_c;
  lane_act_t   lanes;
  out_item_t   result;
  out_item_t   skid_item;
  logic        skid_valid;
  logic        pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stick_thr        <= STICK_THR_RST;
      cfg.trig_thr         <= TRIG_THR_RST;
      cfg.background_input <= 1'b0;
      cfg.auto_switch      <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_STICK_THR:  cfg.stick_thr        <= cfg_data;
        REG_TRIG_THR:   cfg.trig_thr         <= cfg_data;
        REG_BACKGROUND: cfg.background_input <= cfg_data[0];
        REG_AUTO_SW:    cfg.auto_switch      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input handshake
  assign in_ready  = !skid_valid;
  assign accept    = in_valid && in_ready;
  assign tick      = accept && (in_item.kind == KIND_TICK);
  assign stage_key = accept && (in_item.kind == KIND_KEY_WORD);

  assign stick_thr_c = clamp_thr(cfg.stick_thr);
  assign trig_thr_c  = clamp_thr(cfg.trig_thr);

  // stick lanes, sign-extended, and trigger lanes, zero-extended
  for (genvar i = 0; i < 4; i++) begin : g_stick
    isoa_axis_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .tick      (tick),
      .connected (in_item.connected),
      .value     ({in_item.stick_axes[16*i+15], in_item.stick_axes[16*i +: 16]}),
      .thr       (stick_thr_c),
      .act       (axis_act[i])
    );
  end

  for (genvar i = 0; i < 2; i++) begin : g_trig
    isoa_axis_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .tick      (tick),
      .connected (in_item.connected),
      .value     ({1'b0, in_item.trigger_axes[16*i +: 16]}),
      .thr       (trig_thr_c),
      .act       (axis_act[4+i])
    );
  end

  // key staging and key lanes, one per 64-key group
  for (genvar w = 0; w < KEY_WORDS; w++) begin : g_keys
    always_ff @(posedge clk) begin
      if (stage_key && in_item.word_index == 2'(w)) begin
        staged_keys[w] <= in_item.key_word;
      end
    end

    isoa_key_lane u_lane (
      .clk          (clk),
      .rst          (rst),
      .tick_focused (tick && in_item.focused),
      .keys         (staged_keys[w]),
      .mask         (key_mask(w)),
      .act          (key_act[w])
    );
  end

  assign lanes.axis_act = |axis_act;
  assign lanes.key_act  = |key_act;

  // merge stage
  isoa_owner u_owner (
    .clk    (clk),
    .rst    (rst),
    .tick   (tick),
    .item   (in_item),
    .lanes  (lanes),
    .cfg    (cfg),
    .result (result)
  );

  // output register with one skid entry
  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (tick) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_item <= skid_item;
      end
    end else if (tick) begin
      if (!out_valid || pop) begin
        out_item <= result;
      end else begin
        skid_item <= result;
      end
    end
  end

endmodule
